[sv/ffha_pkg.sv]
// Shared types and constants of the first-fit heap allocator.
// Depends on nothing; the interface, controller and core files use it.
package ffha_pkg;

   localparam int MAX_BLOCKS   = 64;
   localparam int HEAP_BYTES   = 65536;
   localparam int HEADER_BYTES = 16;

   localparam int ADDR_W  = 16;
   localparam int LIMIT_W = 17;
   localparam int IDX_W   = $clog2(MAX_BLOCKS);
   localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
   localparam int NEED_W  = LIMIT_W + 1;

   localparam int LIMIT_CAP_INT = (HEAP_BYTES < 65536) ? HEAP_BYTES : 65536;
   localparam logic [LIMIT_W-1:0] LIMIT_CAP   = LIMIT_CAP_INT[LIMIT_W-1:0];
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'h10000;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_NULL     = 2'd1,
      STAT_NOSPACE  = 2'd2,
      STAT_NOTFOUND = 2'd3
   } status_type;

   typedef enum logic {
      KIND_ALLOC = 1'b0,
      KIND_FREE  = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_TAIL,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [ADDR_W-1:0] size;
      logic              free;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] waddr;
      entry_type        wdata;
      logic [IDX_W-1:0] raddr;
   } mem_req_type;

   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] address;
      status_type        status;
   } result_type;

endpackage

[sv/ffha_if.sv]
// Request and response channel interfaces of the heap allocator.
// Depends on ffha_pkg for field widths.
interface ffha_req_if;
   logic                        valid;
   logic                        ready;
   logic                        kind;
   logic [ffha_pkg::ADDR_W-1:0] request_size;
   logic [ffha_pkg::ADDR_W-1:0] block_address;

   modport source (output valid, kind, request_size, block_address, input ready);
   modport sink (input valid, kind, request_size, block_address, output ready);
endinterface

interface ffha_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [ffha_pkg::ADDR_W-1:0] address;
   logic [1:0]                  status;

   modport source (output valid, address, status, input ready);
   modport sink (input valid, address, status, output ready);
endinterface

[sv/ffha_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module ffha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

[sv/ffha_ctrl.sv]
// Sequencer of the allocator: block table scan, append, trim and heap top.
// Depends on ffha_pkg and ffha_req_if; drives the table RAM through mem_req.
module ffha_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   ffha_req_if.sink                      req,
   input  logic [ffha_pkg::LIMIT_W-1:0]  heap_limit,
   input  logic                          out_open,
   input  logic [ffha_pkg::ENTRY_W-1:0]  mem_rdata,
   output ffha_pkg::mem_req_type         mem_req,
   output ffha_pkg::result_type          result
);
   import ffha_pkg::*;

   state_type         state_ff, state_in;
   logic              kind_ff, kind_in;
   logic [ADDR_W-1:0] size_ff, size_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [LIMIT_W-1:0] top_ff, top_in;
   logic [ADDR_W-1:0] res_addr_ff, res_addr_in;
   status_type        res_status_ff, res_status_in;

   entry_type          entry;
   logic               accept, null_req, hit, last, tail, append_ok;
   logic [NEED_W-1:0]  need;
   logic [LIMIT_W-1:0] lim_eff;
   logic [LIMIT_W-1:0] top_pay;

   assign entry   = entry_type'(mem_rdata);
   assign accept  = req.valid && (state_ff == ST_IDLE);
   assign null_req = (req.kind == KIND_ALLOC) ? (req.request_size == '0)
                                              : (req.block_address == '0);
   assign hit     = (kind_ff == KIND_FREE)
                    ? (({1'b0, entry.start} + LIMIT_W'(HEADER_BYTES)) == {1'b0, addr_ff})
                    : (entry.free && (entry.size >= size_ff));
   assign last    = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
   assign tail    = (state_ff == ST_TAIL) || ((state_ff == ST_SCAN) && !hit && last);
   assign need    = NEED_W'(top_ff) + NEED_W'(HEADER_BYTES) + NEED_W'(size_ff);
   assign lim_eff = (heap_limit > LIMIT_CAP) ? LIMIT_CAP : heap_limit;
   assign append_ok = (count_ff < CNT_W'(MAX_BLOCKS)) && (need <= NEED_W'(lim_eff));
   assign top_pay = top_ff + LIMIT_W'(HEADER_BYTES);

   assign req.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (null_req) begin
                  state_in = ST_REPLY;
               end else if (count_ff == '0) begin
                  state_in = ST_TAIL;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (hit || last) begin
               state_in = ST_REPLY;
            end
         end
         ST_TAIL: begin
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            if (out_open) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      kind_in       = kind_ff;
      size_in       = size_ff;
      addr_in       = addr_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      top_in        = top_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      mem_req       = '0;
      result        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            mem_req.raddr = '0;
            if (accept) begin
               kind_in       = req.kind;
               size_in       = req.request_size;
               addr_in       = req.block_address;
               idx_in        = '0;
               res_addr_in   = '0;
               res_status_in = null_req ? STAT_NULL : STAT_OK;
            end
         end
         ST_SCAN: begin
            mem_req.raddr = idx_ff + IDX_W'(1);
            if (hit) begin
               res_status_in = STAT_OK;
               if (kind_ff == KIND_ALLOC) begin
                  mem_req.we    = 1'b1;
                  mem_req.waddr = idx_ff;
                  mem_req.wdata = '{start: entry.start, size: entry.size, free: 1'b0};
                  res_addr_in   = entry.start + ADDR_W'(HEADER_BYTES);
               end else if (last) begin
                  count_in = count_ff - CNT_W'(1);
                  top_in   = LIMIT_W'(entry.start);
               end else begin
                  mem_req.we    = 1'b1;
                  mem_req.waddr = idx_ff;
                  mem_req.wdata = '{start: entry.start, size: entry.size, free: 1'b1};
               end
            end else if (!last) begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         ST_REPLY: begin
            if (out_open) begin
               result.valid   = 1'b1;
               result.address = res_addr_ff;
               result.status  = res_status_ff;
            end
         end
         default: begin
         end
      endcase

      if (tail) begin
         if (kind_ff == KIND_FREE) begin
            res_status_in = STAT_NOTFOUND;
         end else if (append_ok) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = count_ff[IDX_W-1:0];
            mem_req.wdata = '{start: top_ff[ADDR_W-1:0], size: size_ff, free: 1'b0};
            res_addr_in   = top_pay[ADDR_W-1:0];
            res_status_in = STAT_OK;
            count_in      = count_ff + CNT_W'(1);
            top_in        = need[LIMIT_W-1:0];
         end else begin
            res_status_in = STAT_NOSPACE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         top_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         top_ff   <= top_in;
      end
      kind_ff       <= kind_in;
      size_ff       <= size_in;
      addr_ff       <= addr_in;
      idx_ff        <= idx_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
   end
endmodule

[sv/first_fit_heap_allocator_core.sv]
// A null request goes straight to the reply; any other reads table entries in order
// (1..64) until a hit or the last one; on an empty table it goes straight to append.
// The RAM reads one entry per cycle; the next request waits until the last is replied.
// Reset clears entry count, heap top and output valid, and sets heap_limit to 65536;
// table contents need no clearing.
// Top level: holds the limit register and response register, instantiates RAM and ctrl.
module first_fit_heap_allocator_core (
   input  logic                         clock,
   input  logic                         reset,
   ffha_req_if.sink                     req,
   ffha_rsp_if.source                   rsp,
   input  logic                         csr_write_enable,
   input  logic [ffha_pkg::LIMIT_W-1:0] csr_write_data
);
   import ffha_pkg::*;

   logic [LIMIT_W-1:0] limit_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]  rsp_addr_ff, rsp_addr_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;

   logic               out_open;
   mem_req_type        mem_req;
   result_type         result;
   logic [ENTRY_W-1:0] mem_rdata;

   assign out_open = !rsp_valid_ff || rsp.ready;

   ffha_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(MAX_BLOCKS)
   ) u_table (
      .clock (clock),
      .we    (mem_req.we),
      .waddr (mem_req.waddr),
      .wdata (ENTRY_W'(mem_req.wdata)),
      .raddr (mem_req.raddr),
      .rdata (mem_rdata)
   );

   ffha_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .heap_limit (limit_ff),
      .out_open   (out_open),
      .mem_rdata  (mem_rdata),
      .mem_req    (mem_req),
      .result     (result)
   );

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      if (result.valid) begin
         rsp_valid_in  = 1'b1;
         rsp_addr_in   = result.address;
         rsp_status_in = 2'(result.status);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            limit_ff <= csr_write_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.address = rsp_addr_ff;
   assign rsp.status  = rsp_status_ff;
endmodule
